@@ rtl/core/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants for the hash core
// step constants, word permutations, rotation amounts and sequencer states
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int unsigned NumSteps = 26;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;

  typedef enum logic [2:0] {
    ST_IV,      // run message-free steps for the initial value
    ST_IDLE,    // take chunks
    ST_COMP,    // compress the gathered block
    ST_OUT      // hand out digest chunks
  } state_e;

  // what happens after a compression finishes
  typedef enum logic [1:0] {
    AFT_IV,
    AFT_DATA,
    AFT_PAD,
    AFT_FINAL
  } after_e;

  // control from the sequencer to the step unit
  typedef struct packed {
    logic start;    // load chaining value and message halves
    logic step;     // run one step
    logic finish;   // fold last message half into chaining value
  } step_ctl_t;

  localparam word_t ScFirst [8] = '{
    32'h917caf90, 32'h6c1b10a2, 32'h6f352943, 32'hcf778243,
    32'h2ceb7472, 32'h29e96ff2, 32'h8a9ba428, 32'h2eeb2642
  };

  localparam logic [3:0] PermSigma [16] = '{
    4'd6, 4'd4, 4'd5, 4'd7, 4'd12, 4'd15, 4'd14, 4'd13,
    4'd2, 4'd0, 4'd1, 4'd3, 4'd8, 4'd11, 4'd10, 4'd9
  };

  localparam logic [3:0] ExpTau [16] = '{
    4'd3, 4'd2, 4'd0, 4'd1, 4'd7, 4'd4, 4'd5, 4'd6,
    4'd11, 4'd10, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
  };

  localparam logic [4:0] RotGamma [8] = '{
    5'd0, 5'd8, 5'd16, 5'd24, 5'd24, 5'd16, 5'd8, 5'd0
  };

  function automatic word_t rotl(input word_t v, input logic [4:0] r);
    logic [63:0] d;
    d = {v, v} << r;
    return d[63:32];
  endfunction

endpackage

@@ rtl/core/lsh_if.sv @@
// ----------------------------------------------------------------------------
// lsh_if: valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface lsh_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/lsh_step.sv @@
// ----------------------------------------------------------------------------
// lsh_step: one compression step per cycle while the step control is set;
// holds working state, message halves and step constants
// ----------------------------------------------------------------------------
module lsh_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsh_pkg::step_ctl_t   ctl_i,
  input  logic                 odd_i,
  input  lsh_pkg::blk_t        cv_i,
  input  lsh_pkg::blk_t        ma_i,
  input  lsh_pkg::blk_t        mb_i,
  output lsh_pkg::blk_t        cv_o
);

  lsh_pkg::blk_t t_q, t_d, ma_q, ma_d, mb_q, mb_d, mx;
  lsh_pkg::word_t [7:0] sc_q, sc_d;
  logic [4:0] ra, rb;

  always_comb begin
    lsh_pkg::word_t x, y;
    t_d  = t_q;
    ma_d = ma_q;
    mb_d = mb_q;
    sc_d = sc_q;
    ra = odd_i ? 5'd5 : 5'd29;
    rb = odd_i ? 5'd17 : 5'd1;
    mx = t_q;
    for (int l = 0; l < 8; l++) begin
      x = t_q[l] ^ ma_q[l];
      y = t_q[l+8] ^ ma_q[l+8];
      x = x + y;
      x = lsh_pkg::rotl(x, ra) ^ sc_q[l];
      y = y + x;
      y = lsh_pkg::rotl(y, rb);
      x = x + y;
      y = lsh_pkg::rotl(y, lsh_pkg::RotGamma[l]);
      mx[l] = x;
      mx[l+8] = y;
    end
    if (ctl_i.start) begin
      t_d  = cv_i;
      ma_d = ma_i;
      mb_d = mb_i;
      for (int l = 0; l < 8; l++) sc_d[l] = lsh_pkg::ScFirst[l];
    end else if (ctl_i.step) begin
      for (int l = 0; l < 16; l++) begin
        t_d[l]  = mx[lsh_pkg::PermSigma[l]];
        mb_d[l] = mb_q[l] + ma_q[lsh_pkg::ExpTau[l]];
      end
      ma_d = mb_q;
      for (int l = 0; l < 8; l++) sc_d[l] = sc_q[l] + lsh_pkg::rotl(sc_q[l], 5'd8);
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    ma_q <= ma_d;
    mb_q <= mb_d;
    sc_q <= sc_d;
  end

  always_comb begin
    for (int l = 0; l < 16; l++) cv_o[l] = t_q[l] ^ ma_q[l];
  end

  // load, step and fold never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctl_i)) else $error("overlapping step controls");

endmodule

@@ rtl/core/lsh256_hash_core.sv @@
// ----------------------------------------------------------------------------
// lsh256_hash_core: streaming hash of one bit-granular message
// ----------------------------------------------------------------------------
// Chunks of 64 message bits come in on the input channel, sixteen to a
// 1024-bit block. Each chunk is taken while the core is idle; the sixteenth
// starts a compression of 26 steps, one step per cycle on the shared step
// unit, plus a load and a fold, during which no request is taken. The final
// chunk pads in place (or adds a padding block when it fills the block),
// compresses, and the digest goes out as up to four chunks. After reset and
// after each digest or write of digest_bits the initial value is rebuilt by
// message-free steps before the next request is taken.
// ----------------------------------------------------------------------------
module lsh256_hash_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  lsh_if.sink        in_if,
  lsh_if.source      out_if
);

  lsh_pkg::state_e state_q, state_d;
  lsh_pkg::after_e after_q, after_d;
  logic [8:0] bits_q;
  logic [4:0] step_q, step_d;
  logic [3:0] chunk_q, chunk_d;
  logic [1:0] ok_q, ok_d;
  lsh_pkg::blk_t cv_q, step_cv;
  logic [63:0] msg_q [16];
  lsh_pkg::step_ctl_t ctl;
  lsh_pkg::blk_t ma_in, mb_in, cv_in;
  logic start_q, start_d;

  logic [63:0] c_data;
  logic [6:0]  c_vb;
  logic        c_eom;
  assign {c_data, c_vb, c_eom} = in_if.payload;

  // effective digest length
  logic [8:0] eff;
  always_comb begin
    eff = bits_q;
    if (bits_q < 9'd8) eff = 9'd8;
    else if (bits_q > 9'd256) eff = 9'd256;
  end
  logic [5:0] nbytes;
  assign nbytes = eff[8:3];
  logic [1:0] last_k;
  assign last_k = 2'((nbytes - 6'd1) >> 3);

  // padded final chunk
  logic [6:0] vb;
  logic [63:0] keep, padded;
  always_comb begin
    vb = (c_vb > 7'd64) ? 7'd64 : c_vb;
    keep = 64'd0;
    padded = 64'd0;
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < 8; i++) begin
        // bit i of byte b is message bit 8b + 7 - i
        keep[8*b+i] = (7'(8*b + 7 - i) < vb);
        padded[8*b+i] = (7'(8*b + 7 - i) == vb);
      end
    end
    padded = (c_data & keep) | padded;
  end

  assign in_if.ready = (state_q == lsh_pkg::ST_IDLE);
  logic acc;
  assign acc = in_if.valid & in_if.ready;

  // message halves for the step unit: zero while building the iv
  always_comb begin
    cv_in = cv_q;
    for (int c = 0; c < 8; c++) begin
      ma_in[2*c]   = msg_q[c][31:0];
      ma_in[2*c+1] = msg_q[c][63:32];
      mb_in[2*c]   = msg_q[c+8][31:0];
      mb_in[2*c+1] = msg_q[c+8][63:32];
    end
    if (after_q == lsh_pkg::AFT_IV) begin
      ma_in = '0;
      mb_in = '0;
      cv_in = '0;
      cv_in[0] = 32'd32;
      cv_in[1] = {23'd0, eff};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    step_d  = step_q;
    chunk_d = chunk_q;
    ok_d    = ok_q;
    start_d = 1'b0;
    case (state_q)
      lsh_pkg::ST_IV, lsh_pkg::ST_COMP: begin
        if (!start_q) begin
          if (step_q == 5'(lsh_pkg::NumSteps)) begin
            step_d = '0;
            case (after_q)
              lsh_pkg::AFT_IV, lsh_pkg::AFT_DATA: state_d = lsh_pkg::ST_IDLE;
              lsh_pkg::AFT_PAD: begin
                after_d = lsh_pkg::AFT_FINAL;
                start_d = 1'b1;
              end
              default: begin
                state_d = lsh_pkg::ST_OUT;
                ok_d = '0;
              end
            endcase
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      lsh_pkg::ST_IDLE: begin
        if (acc) begin
          chunk_d = chunk_q + 4'd1;
          if (!c_eom) begin
            if (chunk_q == 4'd15) begin
              state_d = lsh_pkg::ST_COMP;
              after_d = lsh_pkg::AFT_DATA;
              start_d = 1'b1;
            end
          end else begin
            chunk_d = '0;
            state_d = lsh_pkg::ST_COMP;
            start_d = 1'b1;
            after_d = (vb == 7'd64 && chunk_q == 4'd15) ? lsh_pkg::AFT_PAD
                                                        : lsh_pkg::AFT_FINAL;
          end
        end
      end
      lsh_pkg::ST_OUT: begin
        if (out_if.ready) begin
          ok_d = ok_q + 2'd1;
          if (ok_q == last_k) begin
            state_d = lsh_pkg::ST_IV;
            after_d = lsh_pkg::AFT_IV;
            start_d = 1'b1;
          end
        end
      end
      default: state_d = lsh_pkg::ST_IV;
    endcase
    if (cfg_we_i) begin
      state_d = lsh_pkg::ST_IV;
      after_d = lsh_pkg::AFT_IV;
      start_d = 1'b1;
      step_d  = '0;
      chunk_d = '0;
    end
  end

  // step unit controls
  always_comb begin
    ctl.start  = start_q;
    ctl.step   = (state_q == lsh_pkg::ST_IV || state_q == lsh_pkg::ST_COMP) &&
                 !start_q && step_q != 5'(lsh_pkg::NumSteps);
    ctl.finish = (state_q == lsh_pkg::ST_IV || state_q == lsh_pkg::ST_COMP) &&
                 !start_q && step_q == 5'(lsh_pkg::NumSteps);
  end

  lsh_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .odd_i  (step_q[0]),
    .cv_i   (cv_in),
    .ma_i   (ma_in),
    .mb_i   (mb_in),
    .cv_o   (step_cv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsh_pkg::ST_IV;
      after_q <= lsh_pkg::AFT_IV;
      step_q  <= '0;
      chunk_q <= '0;
      ok_q    <= '0;
      start_q <= 1'b1;
      bits_q  <= 9'd256;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      step_q  <= step_d;
      chunk_q <= chunk_d;
      ok_q    <= ok_d;
      start_q <= start_d;
      if (cfg_we_i) bits_q <= cfg_wdata_i;
    end
  end

  // chaining value and message block
  always_ff @(posedge clk_i) begin
    if (ctl.finish) cv_q <= step_cv;
    if (acc) begin
      if (!c_eom || vb == 7'd64) msg_q[chunk_q] <= c_data;
      else msg_q[chunk_q] <= padded;
      if (c_eom) begin
        for (int c = 0; c < 16; c++) begin
          if (4'(c) > chunk_q) msg_q[c] <= (c == 32'(chunk_q) + 1 && vb == 7'd64)
                                            ? 64'h80 : 64'd0;
        end
      end
    end
    if (state_q == lsh_pkg::ST_COMP && after_q == lsh_pkg::AFT_PAD &&
        step_q == 5'(lsh_pkg::NumSteps)) begin
      for (int c = 0; c < 16; c++) msg_q[c] <= (c == 0) ? 64'h80 : 64'd0;
    end
  end

  // digest output
  logic [63:0] dchunk, dmask;
  logic [5:0] rem;
  logic [3:0] nb;
  always_comb begin
    dchunk = {cv_q[{1'b0, ok_q, 1'b1}] ^ cv_q[{1'b1, ok_q, 1'b1}],
              cv_q[{1'b0, ok_q, 1'b0}] ^ cv_q[{1'b1, ok_q, 1'b0}]};
    rem = nbytes - {1'b0, ok_q, 3'd0};
    nb = (rem > 6'd8) ? 4'd8 : rem[3:0];
    dmask = '0;
    for (int b = 0; b < 8; b++) if (4'(b) < nb) dmask[8*b +: 8] = 8'hff;
  end
  assign out_if.valid = (state_q == lsh_pkg::ST_OUT);
  assign out_if.payload = {dchunk & dmask, nb, ok_q == last_k};

  // no request taken while the step unit runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.step |-> !in_if.ready) else $error("ready during compression");
  // step counter never passes the step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 5'(lsh_pkg::NumSteps)) else $error("step counter overrun");
  // output only after a final compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(after_q) == lsh_pkg::AFT_FINAL)
    else $error("digest without final block");

endmodule
